// ===== rtl/ccfp_pkg.sv =====
// ============================================================================
// ccfp_pkg: shared types and constants of the coordinate frame parser
// Frame geometry, kind codes, result layout and the front-to-back record.
// ============================================================================
package ccfp_pkg;

  // Frame geometry
  localparam int FRAME_LENGTH = 9;   // bytes per frame, kind byte included
  localparam int KEEP_BYTES   = 9;   // buffer bytes that feed the result
  localparam int COUNT_W      = 4;
  localparam int DATA_BYTES   = 8;   // frame bytes after the kind byte
  localparam int QUEUE_DEPTH  = 2;

  // Received kind byte values
  localparam logic [7:0] KIND_BYTE_RECT   = 8'h08;
  localparam logic [7:0] KIND_BYTE_CENTER = 8'h02;
  localparam logic [7:0] HEADER_RESET     = 8'h2c;

  // Result layout: kind, eight corner bytes, two center bytes, zero pad
  localparam int KIND_W   = 2;
  localparam int OUT_W    = 88;
  localparam int OUT_USED = KIND_W + 8 * (DATA_BYTES + 2);

  typedef enum logic [KIND_W-1:0] {
    KIND_RECT_UPD   = 2'd0,
    KIND_CENTER_UPD = 2'd1,
    KIND_OTHER      = 2'd2
  } kind_t;

  // Completed frame handed from front to back
  typedef struct packed {
    kind_t                           kind;
    logic [DATA_BYTES-1:0][7:0]      data;   // data[i] is frame byte i+1
  } frame_rec_t;

endpackage

// ===== rtl/ccfp_front.sv =====
// ============================================================================
// ccfp_front: byte tracker and frame classifier
// Finds frame starts after the header byte, collects frame bytes and pushes
// one classified record per completed frame.
// ============================================================================
module ccfp_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             header_byte,
  output logic                   push,
  output ccfp_pkg::frame_rec_t   rec
);

  localparam logic [ccfp_pkg::COUNT_W-1:0] LAST_IDX =
    ccfp_pkg::COUNT_W'(ccfp_pkg::FRAME_LENGTH - 1);

  logic                          in_frame;
  logic [ccfp_pkg::COUNT_W-1:0]  byte_count;
  logic [7:0]                    previous_byte;
  logic [7:0]                    frame_buffer [ccfp_pkg::KEEP_BYTES];

  logic                          start;
  logic                          active;
  logic                          last;
  logic [ccfp_pkg::COUNT_W-1:0]  cnt;
  logic [7:0]                    cur_bytes [ccfp_pkg::KEEP_BYTES];

  // Frame position of the current byte
  always_comb begin
    start  = !in_frame && (previous_byte == header_byte);
    active = in_frame || start;
    cnt    = start ? '0 : byte_count;
    last   = (cnt == LAST_IDX);
  end

  // Buffer as it stands with the current byte written in
  always_comb begin
    for (int i = 0; i < ccfp_pkg::KEEP_BYTES; i++) begin
      if (active && (cnt == ccfp_pkg::COUNT_W'(i))) begin
        cur_bytes[i] = rx_byte;
      end else begin
        cur_bytes[i] = frame_buffer[i];
      end
    end
  end

  // Classify the kind byte
  always_comb begin
    if (cur_bytes[0] == ccfp_pkg::KIND_BYTE_RECT) begin
      rec.kind = ccfp_pkg::KIND_RECT_UPD;
    end else if (cur_bytes[0] == ccfp_pkg::KIND_BYTE_CENTER) begin
      rec.kind = ccfp_pkg::KIND_CENTER_UPD;
    end else begin
      rec.kind = ccfp_pkg::KIND_OTHER;
    end
    for (int i = 0; i < ccfp_pkg::DATA_BYTES; i++) begin
      rec.data[i] = cur_bytes[i + 1];
    end
  end

  assign push = accept && active && last;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_count    <= '0;
      previous_byte <= '0;
    end else if (accept) begin
      previous_byte <= rx_byte;
      if (active) begin
        in_frame   <= !last;
        byte_count <= last ? '0 : cnt + 1'b1;
      end
    end
  end

  // Frame buffer; cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ccfp_pkg::KEEP_BYTES; i++) begin
        frame_buffer[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < ccfp_pkg::KEEP_BYTES; i++) begin
        frame_buffer[i] <= cur_bytes[i];
      end
    end
  end

endmodule

// ===== rtl/ccfp_queue.sv =====
// ============================================================================
// ccfp_queue: short record queue between front and back
// Register-based FIFO with simultaneous push and pop.
// ============================================================================
module ccfp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ccfp_pkg::frame_rec_t   push_rec,
  output logic                   full,
  input  logic                   pop,
  output logic                   not_empty,
  output ccfp_pkg::frame_rec_t   head_rec
);

  localparam int PTR_W = (ccfp_pkg::QUEUE_DEPTH > 1) ? $clog2(ccfp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ccfp_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ccfp_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ccfp_pkg::QUEUE_DEPTH);

  ccfp_pkg::frame_rec_t  entries [ccfp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_rec  = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

// ===== rtl/ccfp_back.sv =====
// ============================================================================
// ccfp_back: coordinate update and result register
// Applies each frame record to the held coordinates and presents the result.
// ============================================================================
module ccfp_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 rec_valid,
  input  ccfp_pkg::frame_rec_t                 rec,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ccfp_pkg::OUT_W-1:0]           out_data
);

  localparam int PAD_W = ccfp_pkg::OUT_W - ccfp_pkg::OUT_USED;

  logic [ccfp_pkg::DATA_BYTES-1:0][7:0]  rect_coords;
  logic [1:0][7:0]                       center_coords;
  logic [ccfp_pkg::DATA_BYTES-1:0][7:0]  rect_next;
  logic [1:0][7:0]                       center_next;

  assign pop = rec_valid && (!out_valid || out_ready);

  // Coordinates after this record
  always_comb begin
    rect_next   = rect_coords;
    center_next = center_coords;
    case (rec.kind)
      ccfp_pkg::KIND_RECT_UPD:   rect_next   = rec.data;
      ccfp_pkg::KIND_CENTER_UPD: center_next = rec.data[1:0];
      default:                   ;
    endcase
  end

  // Held coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_coords   <= '0;
      center_coords <= '0;
    end else if (pop) begin
      rect_coords   <= rect_next;
      center_coords <= center_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= {{PAD_W{1'b0}}, center_next, rect_next, rec.kind};
    end
  end

endmodule

// ===== rtl/camera_coordinate_frame_parser.sv =====
// ============================================================================
// camera_coordinate_frame_parser: serial coordinate frame decoder
// Finds header-led frames in a byte stream and reports held coordinates.
// ============================================================================
// Input stream s_*: one received byte per beat. A frame opens on the byte
// after a byte equal to the header register and runs nine bytes: a kind byte
// and eight data bytes. Kind 8 loads the four rectangle corners, kind 2 loads
// the center point, anything else changes nothing.
// Output stream m_*: one beat per completed frame with the kind code and all
// held coordinates after the update.
// Throughput: one byte per cycle while the record queue is not full.
// Result path: a completed frame is written into the record queue, then
// loaded into the result register.
// Receiver stall: the result register holds; records collect in a two-entry
// queue and s_tready drops only while that queue is full.
// Reset (synchronous, rst high): no frame open, previous byte and all
// coordinates zero, header register back to 0x2c.
// cfg_we/cfg_data write the header register; write it only while idle.
module camera_coordinate_frame_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [7:0]                    cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [1:0] frame_kind, [9:2] corner1_x, [17:10] corner1_y, [25:18] corner2_x,
  // [33:26] corner2_y, [41:34] corner3_x, [49:42] corner3_y,
  // [57:50] corner4_x, [65:58] corner4_y, [73:66] center_x,
  // [81:74] center_y, [87:82] zero
  output logic [ccfp_pkg::OUT_W-1:0]    m_tdata
);

  logic                  header_byte_en;
  logic [7:0]            header_byte;
  logic                  accept;
  logic                  push;
  logic                  q_full;
  logic                  q_valid;
  logic                  pop;
  ccfp_pkg::frame_rec_t  push_rec;
  ccfp_pkg::frame_rec_t  head_rec;

  assign header_byte_en = cfg_we;

  // Header register
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= ccfp_pkg::HEADER_RESET;
    end else if (header_byte_en) begin
      header_byte <= cfg_data;
    end
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  ccfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (s_tdata),
    .header_byte (header_byte),
    .push        (push),
    .rec         (push_rec)
  );

  ccfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head_rec  (head_rec)
  );

  ccfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (q_valid),
    .rec       (head_rec),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// ===== rtl/ccfp_checker.sv =====
// ============================================================================
// ccfp_checker: port-level checks of the coordinate frame parser
// Watches the top-level ports only; attached by bind.
// ============================================================================
module ccfp_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [ccfp_pkg::OUT_W-1:0]  m_tdata
);

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid after reset");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // Kind code is one of the three defined codes
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[ccfp_pkg::KIND_W-1:0] != 2'd3)
    else $error("undefined frame kind code");

  // Pad bits above the payload stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[ccfp_pkg::OUT_W-1:ccfp_pkg::OUT_USED] == '0)
    else $error("result pad bits not zero");

endmodule

bind camera_coordinate_frame_parser ccfp_checker u_ccfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
